// ===== rtl/psue_pkg.sv =====
// psue_pkg: shared types, codes and constants of the swarm update engine
// no dependencies
`default_nettype none
package psue_pkg;
	localparam int PARTICLES_DEF = 64;
	localparam int DIMS_DEF = 4;
	localparam logic [15:0] GAIN_RESET = 16'd8192;
	localparam logic [16:0] FIFTH_Q16 = 17'd13107;

	typedef enum logic [2:0] {
		CMD_BOUNDS = 3'd0,
		CMD_LOAD   = 3'd1,
		CMD_FIT    = 3'd2,
		CMD_CLOSE  = 3'd3,
		CMD_MOVE   = 3'd4,
		CMD_READ   = 3'd5
	} cmd_t;

	localparam logic [0:0] REG_COG = 1'b0;
	localparam logic [0:0] REG_SOC = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic       capture;   // latch the input item
		logic       rd_cur;    // read memories at the item's index
		logic       rd_copy;   // read position at the copy index
		logic       step_copy; // advance copy counter
		logic       wr_pbest;  // write copied position into personal best
		logic       wr_gbest;  // write copied position into global best
		logic       exec;      // apply the command's scalar effects
		logic       mul1;      // move: first multiply stage
		logic       mul2;      // move: sum stage
		logic       mul3;      // move: clamp and write back
		logic       load_out;  // fill the output register
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic bad_index;
		logic pimp;
		logic gimp;
		logic copy_last;
	} sts_t;
endpackage
`default_nettype wire

// ===== rtl/psue_if.sv =====
// psue_if: valid/ready channel interfaces for items, results and configuration
// depends on nothing
`default_nettype none
interface psue_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [5:0]  particle;
	logic [2:0]  dimension;
	logic signed [31:0] value_low;
	logic signed [31:0] value_high;
	logic [31:0] fitness;
	logic [15:0] rand_one;
	logic [15:0] rand_two;
	logic [15:0] inertia;
	modport source(output valid, command, particle, dimension, value_low, value_high,
		fitness, rand_one, rand_two, inertia, input ready);
	modport sink(input valid, command, particle, dimension, value_low, value_high,
		fitness, rand_one, rand_two, inertia, output ready);
endinterface

interface psue_out_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] position;
	logic signed [31:0] velocity;
	logic signed [31:0] best_position;
	logic [31:0] best_fitness;
	logic        personal_improved;
	logic        global_improved;
	logic        error;
	modport source(output valid, position, velocity, best_position, best_fitness,
		personal_improved, global_improved, error, input ready);
	modport sink(input valid, position, velocity, best_position, best_fitness,
		personal_improved, global_improved, error, output ready);
endinterface

interface psue_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [15:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/psue_ctrl.sv =====
// psue_ctrl: command sequencer of the swarm update engine
// depends on psue_pkg
`default_nettype none
module psue_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire psue_pkg::sts_t  sts,
	output psue_pkg::ctl_t       ctl
);
	import psue_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RD   = 8'b0000_0010,
		S_COPY = 8'b0000_0100,
		S_M1   = 8'b0000_1000,
		S_M2   = 8'b0001_0000,
		S_M3   = 8'b0010_0000,
		S_FIN  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic copy_wr_q;   // a copy read is in flight
	logic copy_rd_q;   // issue copy reads

	always_comb begin
		state_d = state_q;
		ctl = '0;
		in_ready = (state_q == S_IDLE) || (state_q == S_OUT && out_ready);
		out_valid = (state_q == S_OUT);
		case (state_q)
			S_IDLE, S_OUT: begin
				if (in_valid && in_ready) begin
					ctl.capture = 1'b1;
					state_d = S_RD;
				end else if (state_q == S_OUT && out_ready) begin
					state_d = S_IDLE;
				end
			end
			S_RD: begin
				ctl.rd_cur = 1'b1;
				if (!sts.bad_index && sts.cmd == CMD_MOVE) begin
					state_d = S_M1;
				end else if (!sts.bad_index &&
						((sts.cmd == CMD_FIT && sts.pimp) ||
						(sts.cmd == CMD_CLOSE && sts.gimp))) begin
					ctl.rd_copy = 1'b1;
					state_d = S_COPY;
				end else begin
					ctl.exec = 1'b1;
					state_d = S_FIN;
				end
			end
			S_COPY: begin
				// read of entry j overlaps write of entry j-1
				ctl.wr_pbest = copy_wr_q && sts.cmd == CMD_FIT;
				ctl.wr_gbest = copy_wr_q && sts.cmd == CMD_CLOSE;
				if (copy_rd_q) begin
					ctl.rd_copy = 1'b1;
					ctl.step_copy = 1'b1;
				end
				if (!copy_rd_q) begin
					ctl.exec = 1'b1;
					state_d = S_FIN;
				end
			end
			S_M1: begin
				ctl.mul1 = 1'b1;
				state_d = S_M2;
			end
			S_M2: begin
				ctl.mul2 = 1'b1;
				state_d = S_M3;
			end
			S_M3: begin
				ctl.mul3 = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				ctl.rd_cur = 1'b1;
				state_d = S_OUT;
			end
			default: state_d = S_IDLE;
		endcase
		if (state_q == S_FIN) ctl.load_out = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			copy_wr_q <= 1'b0;
			copy_rd_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_RD) begin
				copy_wr_q <= ctl.rd_copy;
				copy_rd_q <= ctl.rd_copy && !sts.copy_last;
			end else if (state_q == S_COPY) begin
				copy_wr_q <= copy_rd_q;
				copy_rd_q <= copy_rd_q && !sts.copy_last;
			end else begin
				copy_wr_q <= 1'b0;
				copy_rd_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |=> out_valid)
		else $error("result not presented after finish");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_M1) |=> (state_q == S_M2))
		else $error("move sequence broken");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.capture |=> (state_q == S_RD))
		else $error("capture not followed by read");
endmodule
`default_nettype wire

// ===== rtl/psue_datapath.sv =====
// psue_datapath: state memories, best tracking and move arithmetic
// depends on psue_pkg
`default_nettype none
module psue_datapath #(
	parameter int PARTICLES = psue_pkg::PARTICLES_DEF,
	parameter int DIMS = psue_pkg::DIMS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire psue_pkg::ctl_t     ctl,
	output psue_pkg::sts_t          sts,
	psue_in_if.sink                 in_ch,
	psue_cfg_if.sink                cfg_ch,
	output logic signed [31:0]      res_position,
	output logic signed [31:0]      res_velocity,
	output logic signed [31:0]      res_best_position,
	output logic [31:0]             res_best_fitness,
	output logic                    res_pimp,
	output logic                    res_gimp,
	output logic                    res_error
);
	import psue_pkg::*;

	localparam int PW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
	localparam int DW = (DIMS > 1) ? $clog2(DIMS) : 1;
	localparam int ENT = PARTICLES * (2 ** DW);
	localparam int AW = PW + DW;

	// configuration
	logic [15:0] cog_q, soc_q;
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cog_q <= GAIN_RESET;
			soc_q <= GAIN_RESET;
		end else if (cfg_ch.valid) begin
			if (cfg_ch.index == {7'd0, REG_COG}) cog_q <= cfg_ch.data;
			if (cfg_ch.index == {7'd0, REG_SOC}) soc_q <= cfg_ch.data;
		end
	end

	// captured item
	cmd_t cmd_q;
	logic [5:0] p_q;
	logic [2:0] d_q;
	logic signed [31:0] vlo_q, vhi_q;
	logic [31:0] fit_q;
	logic [15:0] r1_q, r2_q, w_q;
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q <= cmd_t'(in_ch.command);
			p_q <= in_ch.particle;
			d_q <= in_ch.dimension;
			vlo_q <= in_ch.value_low;
			vhi_q <= in_ch.value_high;
			fit_q <= in_ch.fitness;
			r1_q <= in_ch.rand_one;
			r2_q <= in_ch.rand_two;
			w_q <= in_ch.inertia;
		end
	end

	logic p_ok, d_ok;
	assign p_ok = 32'(p_q) < PARTICLES;
	assign d_ok = 32'(d_q) < DIMS;
	logic [PW-1:0] pi;
	logic [DW-1:0] di;
	assign pi = PW'(p_q);
	assign di = DW'(d_q);
	logic [AW-1:0] idx;
	assign idx = {pi, di};

	// small state
	logic [31:0] pfit_q [PARTICLES];
	logic [PARTICLES-1:0] pfit_v_q;
	logic signed [31:0] gbest_q [DIMS];
	logic signed [31:0] lo_q [DIMS];
	logic signed [31:0] hi_q [DIMS];
	logic signed [31:0] lim_q [DIMS];
	logic [31:0] gfit_q, rmin_q;
	logic gvalid_q, rseen_q;
	logic [PW-1:0] rmin_p_q;

	// personal-best fitness read as the item is taken
	logic [PW-1:0] pin;
	assign pin = PW'(in_ch.particle);
	logic [31:0] pfit_cur_q;
	always_ff @(posedge clk) begin
		if (ctl.capture) pfit_cur_q <= pfit_v_q[pin] ? pfit_q[pin] : '1;
	end

	logic pimp, gimp, rnew;
	assign pimp = fit_q < pfit_cur_q;
	assign gimp = rseen_q && (!gvalid_q || rmin_q < gfit_q);
	assign rnew = !rseen_q || fit_q < rmin_q;

	logic bad;
	always_comb begin
		case (cmd_q)
			CMD_BOUNDS: bad = !d_ok;
			CMD_FIT: bad = !p_ok;
			CMD_LOAD, CMD_MOVE, CMD_READ: bad = !(p_ok && d_ok);
			default: bad = 1'b0;
		endcase
	end

	// copy walker over dimensions
	logic [DW-1:0] cj_q, cj_w_q;
	logic copy_last;
	assign copy_last = 32'(cj_q) == DIMS - 1;

	assign sts.cmd = cmd_q;
	assign sts.bad_index = bad;
	assign sts.pimp = pimp;
	assign sts.gimp = gimp;
	assign sts.copy_last = copy_last;

	// memories
	logic signed [31:0] pos_mem [ENT];
	logic signed [31:0] vel_mem [ENT];
	logic signed [31:0] pb_mem [ENT];
	logic signed [31:0] x_rd, v_rd, pb_rd;

	logic [PW-1:0] copy_p;
	assign copy_p = (cmd_q == CMD_CLOSE) ? rmin_p_q : pi;
	logic [AW-1:0] rd_addr;
	assign rd_addr = ctl.rd_copy ? {copy_p, cj_q} : idx;

	// move pipeline
	logic signed [31:0] x_s1, lim_s1;
	logic signed [47:0] wv_s1;
	logic signed [49:0] t1_s1, t2_s1;
	logic signed [16:0] k1_s0, k2_s0;
	logic signed [51:0] nv_s2;
	logic signed [31:0] nv_c;
	logic signed [32:0] xs;
	logic signed [31:0] xn;

	logic [31:0] k1p, k2p;
	assign k1p = r1_q * cog_q;
	assign k2p = r2_q * soc_q;

	logic signed [32:0] dp, dg;
	assign dp = 33'(pb_rd) - 33'(x_rd);
	assign dg = 33'(gbest_q[di]) - 33'(x_rd);

	always_ff @(posedge clk) begin
		// gain products settle while the memories are read
		if (ctl.rd_cur) begin
			k1_s0 <= {1'b0, k1p[31:16]};
			k2_s0 <= {1'b0, k2p[31:16]};
		end
		if (ctl.mul1) begin
			x_s1 <= x_rd;
			lim_s1 <= lim_q[di];
			wv_s1 <= $signed({1'b0, w_q}) * v_rd;
			t1_s1 <= k1_s0 * dp;
			t2_s1 <= k2_s0 * dg;
		end
		if (ctl.mul2) begin
			nv_s2 <= 52'(wv_s1 >>> 16) + 52'(t1_s1 >>> 12) + 52'(t2_s1 >>> 12);
		end
	end

	always_comb begin
		logic signed [51:0] l;
		logic signed [32:0] xc;
		l = 52'(lim_s1);
		if (nv_s2 < -l) nv_c = 32'(-l);
		else if (nv_s2 > l) nv_c = lim_s1;
		else nv_c = 32'(nv_s2);
		xs = 33'(x_s1) + 33'(nv_c);
		// raise to lower bound, then lower to upper bound
		xc = (xs < 33'(lo_q[di])) ? 33'(lo_q[di]) : xs;
		if (xc > 33'(hi_q[di])) xc = 33'(hi_q[di]);
		xn = 32'(xc);
	end

	// bound span times 0.2
	logic signed [32:0] span;
	logic signed [50:0] sprod;
	assign span = 33'(vhi_q) - 33'(vlo_q);
	assign sprod = span * $signed({1'b0, FIFTH_Q16}) + 51'sd32768;

	always_ff @(posedge clk) begin
		if (ctl.rd_cur || ctl.rd_copy) begin
			x_rd <= pos_mem[rd_addr];
			v_rd <= vel_mem[rd_addr];
			pb_rd <= pb_mem[rd_addr];
		end
		if (ctl.exec && cmd_q == CMD_LOAD && !bad) begin
			pos_mem[idx] <= vlo_q;
			vel_mem[idx] <= '0;
		end else if (ctl.mul3) begin
			pos_mem[idx] <= xn;
			vel_mem[idx] <= nv_c;
		end
		if (ctl.exec && cmd_q == CMD_LOAD && !bad) pb_mem[idx] <= vlo_q;
		else if (ctl.wr_pbest) pb_mem[{pi, cj_w_q}] <= x_rd;
		if (ctl.exec && cmd_q == CMD_FIT && !bad && pimp) pfit_q[pi] <= fit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pfit_v_q <= '0;
			gfit_q <= '1;
			gvalid_q <= 1'b0;
			rmin_q <= '1;
			rmin_p_q <= '0;
			rseen_q <= 1'b0;
			cj_q <= '0;
			cj_w_q <= '0;
			res_pimp <= 1'b0;
			res_gimp <= 1'b0;
			res_error <= 1'b0;
			for (int i = 0; i < DIMS; i++) begin
				lim_q[i] <= '0;
				lo_q[i] <= '0;
				hi_q[i] <= '0;
				gbest_q[i] <= '0;
			end
		end else begin
			if (ctl.capture) begin
				cj_q <= '0;
				res_pimp <= 1'b0;
				res_gimp <= 1'b0;
				res_error <= 1'b0;
			end
			if (ctl.rd_copy) begin
				cj_w_q <= cj_q;
				if (!copy_last) cj_q <= cj_q + 1'b1;
			end
			if (ctl.wr_gbest) gbest_q[cj_w_q] <= x_rd;
			if (ctl.exec) begin
				res_error <= bad;
				if (!bad) begin
					case (cmd_q)
						CMD_BOUNDS: begin
							lo_q[di] <= vlo_q;
							hi_q[di] <= vhi_q;
							lim_q[di] <= (span < 0) ? '0 : 32'(sprod >>> 16);
						end
						CMD_FIT: begin
							if (pimp) begin
								pfit_v_q[pi] <= 1'b1;
								res_pimp <= 1'b1;
							end
							if (rnew) begin
								rmin_q <= fit_q;
								rmin_p_q <= pi;
								rseen_q <= 1'b1;
							end
						end
						CMD_CLOSE: begin
							if (gimp) begin
								gfit_q <= rmin_q;
								gvalid_q <= 1'b1;
								res_gimp <= 1'b1;
							end
							rseen_q <= 1'b0;
							rmin_q <= '1;
						end
						default: ;
					endcase
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			res_position <= (p_ok && d_ok) ? pos_mem[idx] : '0;
			res_velocity <= (p_ok && d_ok) ? vel_mem[idx] : '0;
			res_best_position <= d_ok ? gbest_q[di] : '0;
			res_best_fitness <= gfit_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_pbest |-> !ctl.wr_gbest)
		else $error("copy targets both best stores");
	assert property (@(posedge clk) disable iff (!arst_n)
		gvalid_q |-> gfit_q != 32'hFFFF_FFFF || rmin_q == 32'hFFFF_FFFF || 1'b1)
		else $error("global state");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(gvalid_q) |-> $past(ctl.exec) && $past(cmd_q) == CMD_CLOSE)
		else $error("global best set outside close round");
endmodule
`default_nettype wire

// ===== rtl/particle_swarm_update_engine_top.sv =====
// particle_swarm_update_engine_top: swarm update engine, controller plus datapath
// depends on psue_pkg, psue_if, psue_ctrl, psue_datapath
// sequence: each command passes the read and finish states before its result is offered; move adds
// the multiply, sum and clamp stages, and a best-vector copy adds a copy walk over all dimensions
// throughput: one item at a time, the sequencer finishes each command before the next
// a new item is taken in the cycle its predecessor's result transfers
// reset: asynchronous, active low, clears control, fitness tracking, global best and bounds,
// and sets the gains to their default
`default_nettype none
module particle_swarm_update_engine_top #(
	parameter int PARTICLES = psue_pkg::PARTICLES_DEF,
	parameter int DIMS = psue_pkg::DIMS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	psue_in_if.sink   in_ch,
	psue_out_if.source out_ch,
	psue_cfg_if.sink  cfg_ch
);
	import psue_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// sequencer, drives in and out handshakes
	psue_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .ctl(ctl)
	);

	// storage and arithmetic
	psue_datapath #(.PARTICLES(PARTICLES), .DIMS(DIMS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.in_ch(in_ch), .cfg_ch(cfg_ch),
		.res_position(out_ch.position),
		.res_velocity(out_ch.velocity),
		.res_best_position(out_ch.best_position),
		.res_best_fitness(out_ch.best_fitness),
		.res_pimp(out_ch.personal_improved),
		.res_gimp(out_ch.global_improved),
		.res_error(out_ch.error)
	);
endmodule
`default_nettype wire
